@@ design/assert_macros.svh @@
// assertion macros used by the conversion controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CHK_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CHK_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/adcc_pkg.sv @@
// types, codes, tables and helper functions of the a/d conversion controller
package adcc_pkg;

  typedef logic [1:0] phase_t;

  localparam phase_t PH_IDLE = 2'd0;
  localparam phase_t PH_ACQ  = 2'd1;
  localparam phase_t PH_CONV = 2'd2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMING   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RC_TAD   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CPI      = 2'd3;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam int CTRL_EN_BIT    = 0;
  localparam int CTRL_GO_BIT    = 1;
  localparam int TIM_RJUST_BIT  = 7;
  localparam logic [7:0] CTRL_GO_CLEAR = 8'hfd;

  localparam logic [3:0] CHAN_FIELD_MASK = 4'hf;

  // width of tad times acquisition or conversion length, in oscillator clocks
  localparam int TIME_W = 13;
  // quotient bits of the shared divider; covers the largest scale of 2^15 - 1
  localparam int QUOT_W = 15;

  // tad in oscillator clocks per clock select; zero means the rc source
  localparam logic [7:0] TAD_CLOCKS [8] = '{8'd2, 8'd8, 8'd32, 8'd0,
                                            8'd4, 8'd16, 8'd64, 8'd0};
  // acquisition time in tad per acquisition select
  localparam logic [4:0] ACQ_TADS [8] = '{5'd0, 5'd2, 5'd4, 5'd6,
                                          5'd8, 5'd12, 5'd16, 5'd20};

  function automatic logic [15:0] format_result(input logic [15:0] r,
                                                input logic [3:0]  bits,
                                                input logic        rjust);
    logic [7:0] hb;
    logic [7:0] lb;
    if (bits > 4'd8) begin
      if (rjust) begin
        hb = {6'b0, r[9:8]};
        lb = r[7:0];
      end else begin
        hb = r[9:2];
        lb = {r[1:0], 6'b0};
      end
    end else begin
      hb = r[7:0];
      lb = 8'd0;
    end
    return {hb, lb};
  endfunction

endpackage

@@ design/adcc_div.sv @@
// restoring divider, one quotient bit per cycle
module adcc_div #(
  parameter int NUM_W  = 33,
  parameter int DEN_W  = 17,
  parameter int QUOT_W = 15
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  dividend,
  input  logic [DEN_W-1:0]  divisor,
  output logic              busy,
  output logic              done,
  output logic [QUOT_W-1:0] quotient
);

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  dsh;
  logic [CNT_W-1:0]  cnt;
  logic              ge;

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      rem      <= dividend;
      dsh      <= NUM_W'(divisor) << (QUOT_W - 1);
      quotient <= '0;
      cnt      <= CNT_W'(QUOT_W);
      busy     <= 1'b1;
      done     <= 1'b0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quotient <= {quotient[QUOT_W-2:0], ge};
      dsh      <= dsh >> 1;
      cnt      <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

@@ design/adc_conversion_controller.sv @@
// A/D conversion controller: takes one request at a time, either an instruction-cycle tick or a
// write of the control register, and returns one result per request with the control readback,
// result bytes, channel, done and busy. Most requests go from acceptance through the push state to
// the output register. A write that starts an acquisition with a nonzero acquisition time, a tick
// that ends an acquisition, and a tick that ends a conversion with the sample strictly between
// separated references run the shared restoring divider, one quotient bit per cycle, for the next
// countdown or for the rounded ratiometric result, then go through the push state. A new request
// is accepted as soon as the result has moved into the output register, even while it waits there.
`include "assert_macros.svh"

module adc_conversion_controller #(
  parameter int VOLT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [7:0]  write_value,
  input  logic [15:0] sample_voltage,
  input  logic [15:0] vref_high,
  input  logic [15:0] vref_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  control_readback,
  output logic [7:0]  result_high,
  output logic [7:0]  result_low,
  output logic [3:0]  selected_channel,
  output logic        done_pulse,
  output logic        busy_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [adcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]  cfg_data
);

  import adcc_pkg::*;

  localparam int HW    = (VOLT_BITS < 16) ? VOLT_BITS : 16;
  localparam int NUM_W = HW + 17;
  localparam int DEN_W = HW + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;

  // configuration
  logic [3:0] adc_bits;
  logic [7:0] timing_control;
  logic [7:0] rc_tad_clocks;
  logic [2:0] clocks_per_instruction;

  // converter state
  logic [7:0]    control_value;
  phase_t        phase;
  logic [15:0]   countdown;
  logic [7:0]    tad_latched;
  logic [HW-1:0] held_sample;
  logic [HW-1:0] held_ref_high;
  logic [HW-1:0] held_ref_low;
  logic [15:0]   result_register;
  logic          done_flag;
  logic          div_ratio;
  logic [1:0]    st;

  // request decode
  logic             in_fire;
  logic             push;
  logic             is_write;
  logic             start;
  logic             busy_now;
  logic [2:0]       cpi_eff;
  logic [7:0]       rc_eff;
  logic [7:0]       tad_sel;
  logic [7:0]       tad_new;
  logic [4:0]       acq;
  logic [TIME_W-1:0] acq_clocks;
  logic [TIME_W-1:0] conv_clocks;
  logic [15:0]      cd_dec;
  logic [15:0]      scale;
  logic [HW-1:0]    sep;
  logic [HW-1:0]    diff;
  logic             no_span;
  logic             at_top;
  logic [NUM_W-1:0] ratio_num;

  // divider
  logic              div_start;
  logic [NUM_W-1:0]  div_n;
  logic [DEN_W-1:0]  div_d;
  logic              div_busy;
  logic              div_done;
  logic [QUOT_W-1:0] div_q;

  assign in_ready  = (st == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign push      = (st == S_PUSH) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      adc_bits               <= 4'd10;
      timing_control         <= 8'd0;
      rc_tad_clocks          <= 8'd6;
      clocks_per_instruction <= 3'd4;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ADC_BITS: adc_bits               <= cfg_data[3:0];
        REG_TIMING:   timing_control         <= cfg_data;
        REG_RC_TAD:   rc_tad_clocks          <= cfg_data;
        REG_CPI:      clocks_per_instruction <= cfg_data[2:0];
      endcase
    end
  end

  always_comb begin
    is_write = (operation == OP_WRITE);
    start    = is_write && write_value[CTRL_EN_BIT] && write_value[CTRL_GO_BIT]
               && !control_value[CTRL_GO_BIT];
    busy_now = (phase == PH_ACQ) || (phase == PH_CONV);
    cpi_eff  = (clocks_per_instruction == 3'd0) ? 3'd1 : clocks_per_instruction;
    rc_eff   = (rc_tad_clocks < 8'd2) ? 8'd2 : rc_tad_clocks;
    tad_sel  = TAD_CLOCKS[timing_control[2:0]];
    tad_new  = (tad_sel == 8'd0) ? rc_eff : tad_sel;
    acq      = ACQ_TADS[timing_control[5:3]];
    acq_clocks  = TIME_W'(acq) * TIME_W'(tad_new);
    conv_clocks = TIME_W'({1'b0, adc_bits} + 5'd1) * TIME_W'(tad_latched);
    cd_dec   = countdown - 16'd1;
    // ratio terms from the held voltages
    scale    = (16'd1 << adc_bits) - 16'd1;
    sep      = held_ref_high - held_ref_low;
    diff     = held_sample - held_ref_low;
    no_span  = (held_ref_high <= held_ref_low) || (held_sample <= held_ref_low);
    at_top   = (held_sample >= held_ref_high);
    // 2*scale*diff + sep, with scale = 2^bits - 1
    ratio_num = (NUM_W'(diff) << ({1'b0, adc_bits} + 5'd1)) - (NUM_W'(diff) << 1)
                + NUM_W'(sep);
  end

  always_comb begin
    div_start = 1'b0;
    div_n     = NUM_W'(acq_clocks);
    div_d     = DEN_W'(cpi_eff);
    if (in_fire) begin
      if (is_write) begin
        div_start = start && (acq != 5'd0);
      end else if (busy_now && (cd_dec == 16'd0)) begin
        if (phase == PH_ACQ) begin
          div_start = 1'b1;
          div_n     = NUM_W'(conv_clocks);
        end else if (!(no_span || at_top)) begin
          div_start = 1'b1;
          div_n     = ratio_num;
          div_d     = {sep, 1'b0};
        end
      end
    end
  end

  adcc_div #(
    .NUM_W  (NUM_W),
    .DEN_W  (DEN_W),
    .QUOT_W (QUOT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st              <= S_IDLE;
      control_value   <= 8'd0;
      phase           <= PH_IDLE;
      countdown       <= 16'd0;
      tad_latched     <= 8'd0;
      held_sample     <= '0;
      held_ref_high   <= '0;
      held_ref_low    <= '0;
      result_register <= 16'd0;
      done_flag       <= 1'b0;
      div_ratio       <= 1'b0;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (in_fire) begin
            done_flag <= 1'b0;
            st        <= div_start ? S_DIV : S_PUSH;
            div_ratio <= 1'b0;
            if (is_write) begin
              control_value <= write_value;
              if (write_value[CTRL_EN_BIT]) begin
                if (start) begin
                  tad_latched <= tad_new;
                  phase       <= PH_ACQ;
                  if (acq == 5'd0) begin
                    countdown <= 16'd1;
                  end
                end
              end else begin
                phase     <= PH_IDLE;
                countdown <= 16'd0;
              end
            end else if (busy_now) begin
              countdown <= cd_dec;
              if (cd_dec == 16'd0) begin
                if (phase == PH_ACQ) begin
                  held_sample   <= sample_voltage[HW-1:0];
                  held_ref_high <= vref_high[HW-1:0];
                  held_ref_low  <= vref_low[HW-1:0];
                  phase         <= PH_CONV;
                end else if (no_span || at_top) begin
                  result_register <= format_result(no_span ? 16'd0 : scale, adc_bits,
                                                   timing_control[TIM_RJUST_BIT]);
                  control_value   <= control_value & CTRL_GO_CLEAR;
                  done_flag       <= 1'b1;
                  phase           <= PH_IDLE;
                end else begin
                  div_ratio <= 1'b1;
                end
              end
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            st <= S_PUSH;
            if (div_ratio) begin
              result_register <= format_result(16'(div_q), adc_bits,
                                               timing_control[TIM_RJUST_BIT]);
              control_value   <= control_value & CTRL_GO_CLEAR;
              done_flag       <= 1'b1;
              phase           <= PH_IDLE;
            end else begin
              // a delay that divides to nothing still lasts one tick
              countdown <= (div_q == '0) ? 16'd1 : 16'(div_q);
            end
          end
        end
        S_PUSH: begin
          if (push) begin
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // output register, refilled only once the previous result has gone
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      control_readback <= control_value;
      result_high      <= result_register[15:8];
      result_low       <= result_register[7:0];
      selected_channel <= control_value[5:2] & CHAN_FIELD_MASK;
      done_pulse       <= done_flag;
      busy_res         <= (phase == PH_ACQ) || (phase == PH_CONV);
    end
  end

  `CHK_IMP(a_busy_has_count, st == S_IDLE && phase != PH_IDLE, countdown != 16'd0, "empty count")
  `CHK_IMP(a_div_running, st == S_DIV, div_busy || div_done, "waiting on idle divider")
  `CHK_IMP(a_done_not_busy, out_valid && done_pulse, !busy_res, "done reported while busy")
  `CHK_NXT(a_push_shows, push, out_valid && st == S_IDLE, "result not presented after push")

endmodule
